/* rtl/core/wmf_pkg.sv */
// Package for the window mode filter: sizes, sequencer states and the
// control word of the match counter. No dependencies.
`default_nettype none

package wmf_pkg;

   // Window storage depth
   localparam int MAX_WINDOW = 8;

   // Fixed field widths
   localparam int SAMPLE_W  = 20;
   localparam int COUNT_W   = 4;
   localparam int LEN_W     = 4;
   localparam logic [LEN_W-1:0] LEN_RESET = 4'd5;

   // Derived widths: store index and internal count (holds MAX_WINDOW)
   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Control word for the match counter
   typedef struct packed {
      logic start;   // load count with one (the new sample itself)
      logic step;    // compare one stored entry, count on a match
   } cnt_ctrl_type;

endpackage

`default_nettype wire

/* rtl/core/window_mode_filter.sv */
// Window mode filter: reports the most frequent sample of each window.
// Each accepted word is compared in ST_SCAN against the pos earlier samples in
// the window (pos = 0..MAX_WINDOW-1; no scan at 0), then stored in ST_UPDATE;
// a closing word also loads the result. The single comparator takes no new word
// until the sequencer is back in ST_IDLE; a closing word waits on a stalled result.
// Sync active-high reset: length 5, empty window, no result; store undefined.
`default_nettype none

module window_mode_filter
   import wmf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_wr_en,
   input  wire logic [LEN_W-1:0]    csr_wr_data,
   // sample input
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   // mode result
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [SAMPLE_W-1:0] rsp_mode_value,
   output logic      [COUNT_W-1:0]  rsp_mode_count
);

   // Registers
   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    win_len_ff;
   logic [IDX_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                close_ff, close_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] best_value_ff, best_value_in;
   logic [CNT_W-1:0]    best_count_ff, best_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic [SAMPLE_W-1:0] store_ff [MAX_WINDOW];
   logic [SAMPLE_W-1:0] store_rd_ff;

   // Misc
   logic             accept;
   logic             out_free;
   logic             last_cmp;
   logic             finish;
   logic [CNT_W-1:0] eff_len;
   logic [CNT_W-1:0] match_count;
   logic             better;
   cnt_ctrl_type     cnt_ctrl;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_cmp = (idx_ff == (pos_ff - IDX_W'(1)));
   assign better   = (match_count > best_count_ff);

   // Effective window length: zero acts as one, saturate at the store depth
   always_comb begin
      if (win_len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (int'(win_len_ff) > MAX_WINDOW) begin
         eff_len = CNT_W'(MAX_WINDOW);
      end else begin
         eff_len = CNT_W'(win_len_ff);
      end
   end

   // Slot for the new word; clamp when the length shrank mid-window
   always_comb begin
      if (CNT_W'(fill_ff) >= eff_len) begin
         pos_in = IDX_W'(eff_len - CNT_W'(1));
      end else begin
         pos_in = fill_ff;
      end
      close_in = ((CNT_W'(pos_in) + CNT_W'(1)) >= eff_len);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (pos_in == '0) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_cmp) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!close_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall      = 1'b1;
      cnt_ctrl.start = 1'b0;
      cnt_ctrl.step  = 1'b0;
      finish         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            cnt_ctrl.start = 1'b1;
         end
         ST_SCAN: begin
            cnt_ctrl.step = 1'b1;
         end
         ST_UPDATE: begin
            finish = !close_ff || out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Scan index: store read is registered, so the read runs one ahead
   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         idx_in = '0;
      end else if (state_ff == ST_SCAN) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // Window bookkeeping and result load
   always_comb begin
      fill_in       = fill_ff;
      best_value_in = best_value_ff;
      best_count_in = best_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (finish) begin
         if (close_ff) begin
            fill_in       = '0;
            best_value_in = '0;
            best_count_in = '0;
            rsp_valid_in  = 1'b1;
         end else begin
            fill_in = pos_ff + IDX_W'(1);
            if (better) begin
               best_value_in = sample_ff;
               best_count_in = match_count;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         win_len_ff    <= LEN_RESET;
         fill_ff       <= '0;
         best_value_ff <= '0;
         best_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         best_value_ff <= best_value_in;
         best_count_ff <= best_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            win_len_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         sample_ff <= req_sample;
         pos_ff    <= pos_in;
         close_ff  <= close_in;
      end
      if (finish && close_ff) begin
         rsp_value_ff <= better ? sample_ff : best_value_ff;
         rsp_count_ff <= better ? match_count : best_count_ff;
      end
   end

   // Window store: written once per word, read one entry a cycle
   always_ff @(posedge clock) begin
      if (finish) begin
         store_ff[pos_ff] <= sample_ff;
      end
      store_rd_ff <= store_ff[idx_in];
   end

   // Shared comparator and match counter
   wmf_match_counter u_match_counter (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cnt_ctrl),
      .sample (sample_ff),
      .entry  (store_rd_ff),
      .count  (match_count)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_value = rsp_value_ff;
   assign rsp_mode_count = COUNT_W'(rsp_count_ff);

endmodule

`default_nettype wire

/* rtl/core/wmf_match_counter.sv */
// Shared compare-and-count unit: one stored entry against the held sample
// per cycle while step is set. Depends on wmf_pkg.
`default_nettype none

module wmf_match_counter
   import wmf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cnt_ctrl_type        ctrl,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic [SAMPLE_W-1:0] entry,
   output logic      [CNT_W-1:0]    count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Next count: reload on start, bump on a match
   always_comb begin
      count_in = count_ff;
      if (ctrl.start) begin
         count_in = CNT_W'(1);
      end else if (ctrl.step && (entry == sample)) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

/* sim/window_mode_filter_tb.sv */
`timescale 1ns / 1ps
// Testbench for window_mode_filter: random and directed sample words, a mode
// predictor per window and a per-field check of every result word.
// Depends on wmf_pkg and the window_mode_filter RTL.

module window_mode_filter_tb;
   import wmf_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = MAX_WINDOW + 4;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_MAX    = 10;
   localparam int RAND_PHASES   = 12;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic [COUNT_W-1:0]  count;
   } mode_word_type;

   // DUT ports; the inputs are all known from time zero
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [LEN_W-1:0]    csr_wr_data = LEN_RESET;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample  = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [SAMPLE_W-1:0] rsp_mode_value;
   logic [COUNT_W-1:0]  rsp_mode_count;

   // stimulus and expectations
   logic [SAMPLE_W-1:0] sample_q[$];
   mode_word_type       mode_expect_q[$];
   int                  tx_idle_pct = 0;
   int                  rx_idle_pct = 0;
   int                  err_count   = 0;
   int                  samples_in  = 0;
   int                  modes_seen  = 0;
   int                  cycles      = 0;

   // long receiver hold-off
   logic                hold_arm    = 1'b0;
   logic                hold_taken  = 1'b0;
   int                  hold_left   = 0;

   // predictor state
   logic [LEN_W-1:0]    win_len = LEN_RESET;
   logic [SAMPLE_W-1:0] win_store[MAX_WINDOW];
   int                  win_fill = 0;
   logic [SAMPLE_W-1:0] best_val = '0;
   int                  best_cnt = 0;

   window_mode_filter DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mode_value (rsp_mode_value),
      .rsp_mode_count (rsp_mode_count)
   );

   always #CLK_HALF clock = ~clock;

   // Add one sample to the window; queue the mode word when the window closes.
   function automatic void mode_predict(input logic [SAMPLE_W-1:0] s);
      int            len;
      int            pos;
      int            hits;
      mode_word_type w;
      len = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
      // a length shortened to at most the fill closes the window on the next sample
      pos  = (win_fill >= len) ? len - 1 : win_fill;
      hits = 1;
      for (int i = 0; i < pos; i++)
         if (win_store[i] == s) hits++;
      win_store[pos] = s;
      // strict compare: ties keep the value that reached the count first
      if (hits > best_cnt) begin
         best_cnt = hits;
         best_val = s;
      end
      if (pos + 1 >= len) begin
         w.value = best_val;
         w.count = best_cnt[COUNT_W-1:0];
         mode_expect_q.push_back(w);
         win_fill = 0;
         best_val = '0;
         best_cnt = 0;
      end else begin
         win_fill = pos + 1;
      end
   endfunction

   function automatic void report_mismatch(input string what, input mode_word_type want,
                                           input mode_word_type got);
      if (err_count < REPORT_MAX)
         $display("%t: %s: expected value %h count %0d, got value %h count %0d",
                  $realtime, what, want.value, want.count, got.value, got.count);
      err_count++;
   endfunction

   // Wait for the block to drain, then give it time to finish a silent word.
   task automatic settle();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_valid || mode_expect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_length(input logic [LEN_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      win_len = v;
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Driver: present the next queued word, hold it while stalled
   always @(posedge clock) begin : drive
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            mode_predict(req_sample);
            samples_in++;
         end
         if (!req_valid || !req_stall) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_sample <= sample_q.pop_front();
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result word against the oldest expectation
   always @(posedge clock) begin : monitor
      mode_word_type got;
      mode_word_type want;
      got.value = rsp_mode_value;
      got.count = rsp_mode_count;
      if (!reset && rsp_valid && !rsp_stall) begin
         modes_seen++;
         if (mode_expect_q.size() == 0) begin
            report_mismatch("unexpected result word", '0, got);
         end else begin
            want = mode_expect_q.pop_front();
            if (got.value !== want.value || got.count !== want.count)
               report_mismatch("result mismatch", want, got);
         end
      end
      rsp_stall <= !reset && ((hold_left != 0) || ($urandom_range(99) < rx_idle_pct));
   end

   // Receiver hold-off counter
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_taken) begin
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("window_mode_filter_tb: done, errors");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      logic [LEN_W-1:0]    lengths[RAND_PHASES];
      logic [SAMPLE_W-1:0] pool[4];
      logic [31:0]         r;
      int                  pool_size;
      int                  n;
      int                  idle_mode;

      lengths = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd2, 4'd7, 4'd9, 4'd4, 4'd6, 4'd5, 4'd8};
      pool_size = 1;
      tx_idle_pct = 29;
      rx_idle_pct = 64;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset length: extremes of the sample range, mode found late in the window
      sample_q.push_back('0);
      sample_q.push_back('1);
      sample_q.push_back('1);
      sample_q.push_back('0);
      sample_q.push_back('0);
      settle();

      // zero length behaves as one
      set_length(4'd0);
      sample_q.push_back('1);
      sample_q.push_back(20'hAAAAA);
      settle();

      // length above the store saturates; all-equal window gives the top count
      set_length(4'd15);
      repeat (MAX_WINDOW) sample_q.push_back(20'h55555);
      settle();

      // tie: earliest value to reach the top count wins
      set_length(4'd4);
      sample_q.push_back(20'd7);
      sample_q.push_back(20'd9);
      sample_q.push_back(20'd9);
      sample_q.push_back(20'd7);
      settle();

      // shorten the length mid-window: the next sample closes it
      set_length(4'd8);
      repeat (3) sample_q.push_back(20'd5);
      settle();
      set_length(4'd2);
      sample_q.push_back(20'd6);
      settle();

      // random phases over several lengths and idle patterns
      for (int p = 0; p < RAND_PHASES; p++) begin
         idle_mode   = p * 3 / RAND_PHASES;
         tx_idle_pct = (idle_mode == 0) ? 29 : ((idle_mode == 1) ? 64 : 0);
         rx_idle_pct = (idle_mode == 0) ? 64 : ((idle_mode == 1) ? 29 : 0);
         set_length(lengths[p]);
         // one result per word here, so a long hold-off backs up the input
         if (p == 0) hold_arm <= 1'b1;
         n = $urandom_range(55, 85);
         for (int k = 0; k < n; k++) begin
            // small pool of values, some one bit apart, to force repeats
            if (k % MAX_WINDOW == 0) begin
               pool_size = $urandom_range(1, 4);
               for (int j = 0; j < 4; j++) begin
                  r = $urandom();
                  pool[j] = r[SAMPLE_W-1:0];
                  if (j != 0 && $urandom_range(1) == 1)
                     pool[j] = pool[0] ^ (20'd1 << $urandom_range(SAMPLE_W - 1));
               end
            end
            r = $urandom();
            if ($urandom_range(99) < 85)
               sample_q.push_back(pool[$urandom_range(pool_size - 1)]);
            else
               sample_q.push_back(r[SAMPLE_W-1:0]);
         end
         settle();
      end

      err_count += mode_expect_q.size();
      $display("Ran %0d samples and %0d mode words; window lengths 0 to 15, ties,",
               samples_in, modes_seen);
      $display("length changes mid-window and a long result hold-off; %0d mismatches.",
               err_count);
      if (err_count == 0)
         $display("window_mode_filter_tb: done, clean");
      else
         $display("window_mode_filter_tb: done, errors");
      $finish;
   end

endmodule
